@@ rtl/core/ftws_pkg.sv @@
package ftws_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 60;
    localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int DUR_W   = 24;
    localparam int OCNT_W  = 6;
    localparam int CFG_A_W = 3;

    localparam int S_TDATA_W = ((DUR_W + 7) / 8) * 8;
    localparam int M_FIELD_W = 4 * DUR_W + 6 * OCNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Reset contents of the window and the registers
    localparam logic [DUR_W-1:0] RESET_DURATION   = DUR_W'(16670);
    localparam logic [DUR_W-1:0] RST_EDGE_FAST    = DUR_W'(8000);
    localparam logic [DUR_W-1:0] RST_EDGE_MID     = DUR_W'(16670);
    localparam logic [DUR_W-1:0] RST_EDGE_SLOW    = DUR_W'(33330);
    localparam logic [DUR_W-1:0] RST_SPIKE_LOW    = DUR_W'(16670);
    localparam logic [DUR_W-1:0] RST_SPIKE_HIGH   = DUR_W'(33330);

    // Rank of the percentile entry: floor(N * 0.99), clamped to N-1
    localparam int RANK_RAW = (WINDOW_DEPTH * 99) / 100;
    localparam int RANK_K   = (RANK_RAW >= WINDOW_DEPTH) ? WINDOW_DEPTH - 1 : RANK_RAW;

    typedef enum logic [CFG_A_W-1:0] {
        REG_EDGE_FAST  = 3'd0,
        REG_EDGE_MID   = 3'd1,
        REG_EDGE_SLOW  = 3'd2,
        REG_SPIKE_LOW  = 3'd3,
        REG_SPIKE_HIGH = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        FUNC_RECORD = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATS,
        ST_CAND,
        ST_INNER,
        ST_JUDGE,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_STAT,
        RD_CAND,
        RD_INNER
    } rd_kind_t;

    function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] n);
        logic [CNT_W+OCNT_W-1:0] wide;
        wide = (CNT_W + OCNT_W)'(n);
        if (wide > (CNT_W + OCNT_W)'({OCNT_W{1'b1}})) begin
            return {OCNT_W{1'b1}};
        end
        return OCNT_W'(wide);
    endfunction

endpackage

@@ rtl/core/frame_time_window_statistics.sv @@
// Channel   Direction  Payload
// s_*       in         tuser: func; tdata: frame_time_us
// m_*       out        tdata: latest, min, max, four bin counts, percentile, two spike counts
// cfg_*     in         register index and 24-bit value, one write per cycle
//
// A record item leaves the block in the idle state, so it stays ready for the next item.
// A query makes one pass of N window reads for min, max and counts, then
// a rank search that reloads one candidate and rescans the whole window
// through the single RAM read port, stopping at the first candidate that
// holds the rank.
// Reset is synchronous; the window reads as 16670 until each slot is written.
// A query result waits in the output register; records are taken meanwhile.
module frame_time_window_statistics
    import ftws_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [23:0] frame_time_us
    input  logic [0:0]           s_tuser,  // [0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [23:0] latest_us, [47:24] window_min_us, [71:48] window_max_us,
    // [77:72] count_fast, [83:78] count_normal, [89:84] count_slow,
    // [95:90] count_very_slow, [119:96] percentile_us, [125:120] spikes_low,
    // [131:126] spikes_high, upper bits zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [DUR_W-1:0]     cfg_wdata
);

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] K_RANK   = CNT_W'(RANK_K);

    state_t   state_reg, state_next;
    rd_kind_t rd_kind_reg, rd_kind_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] cand_idx_reg, cand_idx_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rd_tag_reg;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] last_idx;
    logic [WINDOW_DEPTH-1:0] valid_reg;

    logic [DUR_W-1:0] edge_fast_reg, edge_mid_reg, edge_slow_reg;
    logic [DUR_W-1:0] spike_low_reg, spike_high_reg;

    logic [DUR_W-1:0] ram_rdata, rd_val;
    logic             rec_we;
    logic             in_fire;
    logic             out_load;
    logic             found;

    logic [DUR_W-1:0] latest_reg, min_reg, max_reg, first_reg, cand_reg, pct_reg;
    logic [CNT_W-1:0] c_fast_reg, c_norm_reg, c_slow_reg, c_vslow_reg;
    logic [CNT_W-1:0] sp_low_reg, sp_high_reg, below_reg, atb_reg;

    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic hit_fast, hit_norm, hit_slow, hit_vslow;

    assign in_fire  = s_tvalid && s_tready;
    assign rec_we   = in_fire && (s_tuser[0] == FUNC_RECORD);
    assign last_idx = (wptr_reg == '0) ? LAST_IDX : wptr_reg - PTR_W'(1);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign found    = (below_reg <= K_RANK) && (K_RANK < atb_reg);
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    ftws_ram #(
        .WIDTH (DUR_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (rec_we),
        .wr_addr (wptr_reg),
        .wr_data (s_tdata[DUR_W-1:0]),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Unwritten slots read as the reset fill
    assign rd_val = valid_reg[rd_tag_reg] ? ram_rdata : RESET_DURATION;

    assign hit_fast  = rd_val < edge_fast_reg;
    assign hit_norm  = !hit_fast && (rd_val < edge_mid_reg);
    assign hit_slow  = !hit_fast && !hit_norm && (rd_val < edge_slow_reg);
    assign hit_vslow = !hit_fast && !hit_norm && !hit_slow;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cand_idx_next = cand_idx_reg;
        rd_kind_next  = RD_NONE;
        rd_addr       = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_tuser[0] == FUNC_QUERY)) begin
                    state_next = ST_STATS;
                    cnt_next   = '0;
                end
            end
            ST_STATS: begin
                rd_kind_next  = RD_STAT;
                cand_idx_next = '0;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = ST_CAND;
                end else begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            ST_CAND: begin
                rd_addr      = cand_idx_reg;
                rd_kind_next = RD_CAND;
                cnt_next     = '0;
                state_next   = ST_INNER;
            end
            ST_INNER: begin
                rd_kind_next = RD_INNER;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = ST_JUDGE;
                end else begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            ST_JUDGE: begin
                // last inner read is counted here
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (found || (cand_idx_reg == LAST_IDX)) begin
                    state_next = ST_DONE;
                end else begin
                    cand_idx_next = cand_idx_reg + PTR_W'(1);
                    state_next    = ST_CAND;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        wptr_next = wptr_reg;
        if (rec_we) begin
            wptr_next = (wptr_reg == LAST_IDX) ? '0 : wptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_kind_reg    <= RD_NONE;
            cnt_reg        <= '0;
            cand_idx_reg   <= '0;
            wptr_reg       <= '0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            edge_fast_reg  <= RST_EDGE_FAST;
            edge_mid_reg   <= RST_EDGE_MID;
            edge_slow_reg  <= RST_EDGE_SLOW;
            spike_low_reg  <= RST_SPIKE_LOW;
            spike_high_reg <= RST_SPIKE_HIGH;
        end else begin
            state_reg    <= state_next;
            rd_kind_reg  <= rd_kind_next;
            cnt_reg      <= cnt_next;
            cand_idx_reg <= cand_idx_next;
            wptr_reg     <= wptr_next;
            if (rec_we) begin
                valid_reg[wptr_reg] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_EDGE_FAST:  edge_fast_reg  <= cfg_wdata;
                    REG_EDGE_MID:   edge_mid_reg   <= cfg_wdata;
                    REG_EDGE_SLOW:  edge_slow_reg  <= cfg_wdata;
                    REG_SPIKE_LOW:  spike_low_reg  <= cfg_wdata;
                    REG_SPIKE_HIGH: spike_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Datapath: consume the read issued in the cycle before
    always_ff @(posedge aclk) begin
        rd_tag_reg <= rd_addr;
        unique case (rd_kind_reg)
            RD_STAT: begin
                if (rd_tag_reg == '0) begin
                    min_reg     <= rd_val;
                    max_reg     <= rd_val;
                    first_reg   <= rd_val;
                    c_fast_reg  <= CNT_W'(hit_fast);
                    c_norm_reg  <= CNT_W'(hit_norm);
                    c_slow_reg  <= CNT_W'(hit_slow);
                    c_vslow_reg <= CNT_W'(hit_vslow);
                    sp_low_reg  <= CNT_W'(rd_val > spike_low_reg);
                    sp_high_reg <= CNT_W'(rd_val > spike_high_reg);
                end else begin
                    if (rd_val < min_reg) begin
                        min_reg <= rd_val;
                    end
                    if (rd_val > max_reg) begin
                        max_reg <= rd_val;
                    end
                    c_fast_reg  <= c_fast_reg + CNT_W'(hit_fast);
                    c_norm_reg  <= c_norm_reg + CNT_W'(hit_norm);
                    c_slow_reg  <= c_slow_reg + CNT_W'(hit_slow);
                    c_vslow_reg <= c_vslow_reg + CNT_W'(hit_vslow);
                    sp_low_reg  <= sp_low_reg + CNT_W'(rd_val > spike_low_reg);
                    sp_high_reg <= sp_high_reg + CNT_W'(rd_val > spike_high_reg);
                end
                if (rd_tag_reg == last_idx) begin
                    latest_reg <= rd_val;
                end
            end
            RD_CAND: begin
                cand_reg  <= rd_val;
                below_reg <= '0;
                atb_reg   <= '0;
            end
            RD_INNER: begin
                below_reg <= below_reg + CNT_W'(rd_val < cand_reg);
                atb_reg   <= atb_reg + CNT_W'(rd_val <= cand_reg);
            end
            RD_NONE: ;
            default: ;
        endcase
        if (state_reg == ST_DECIDE) begin
            // fall back to slot zero if no candidate covers the rank
            pct_reg <= found ? cand_reg : first_reg;
        end
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({sat_cnt(sp_high_reg), sat_cnt(sp_low_reg), pct_reg,
                                       sat_cnt(c_vslow_reg), sat_cnt(c_slow_reg),
                                       sat_cnt(c_norm_reg), sat_cnt(c_fast_reg),
                                       max_reg, min_reg, latest_reg});
        end
    end

`ifndef SYNTHESIS
    a_query_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == FUNC_QUERY)) |=> (state_reg == ST_STATS))
        else $error("query accepted without starting the window scan");

    a_wptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wptr_reg <= LAST_IDX)
        else $error("write pointer beyond window");

    a_inner_in_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_kind_reg == RD_INNER) |-> (state_reg == ST_INNER || state_reg == ST_JUDGE))
        else $error("inner read consumed outside the rank scan");

    a_done_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) |=>
            (m_tvalid && state_reg == ST_IDLE))
        else $error("finished query not presented");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> ($stable(wptr_reg) || $past(state_reg) == ST_IDLE))
        else $error("window written during a query");
`endif

endmodule

@@ rtl/core/ftws_ram.sv @@
module ftws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 60
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
